### sv/wlcb_pkg.sv
// wlcb_pkg: shared constants for the weighted layer color blend core.
// Field widths, stream word widths and parameter defaults.
// No dependencies.
package wlcb_pkg;

	// parameter defaults
	localparam int MAX_LAYERS_DEF       = 16;
	localparam int WEIGHT_FRAC_BITS_DEF = 12;

	// item field widths
	localparam int COLOR_W  = 8;
	localparam int WEIGHT_W = 16;
	localparam int NUM_CH   = 3;

	// stream word widths
	localparam int S_DATA_W = 64;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 24;

	// width that holds any weight and the unit alpha for compares
	localparam int CMP_W = 17;

endpackage

### sv/weighted_layer_color_blend_core.sv
// weighted_layer_color_blend_core: bit-serial weighted-average alpha blend, RGB888; uses wlcb_pkg.
// A layer word with a contribution is accepted, then added by serial shift-add multiply steps,
// one color bit per step; a word without a contribution is only accepted. A last word then
// goes through ST_PREP, the shift-add multiplier (ST_MULA, ST_MULT), the restoring divider
// (ST_DIV) and ST_DONE; zero total weight skips to ST_DONE. A held result word stalls the next.
// Reset (arst_n low, asynchronous) clears all accumulators and empties the output.
module weighted_layer_color_blend_core #(
	parameter int MAX_LAYERS       = wlcb_pkg::MAX_LAYERS_DEF,
	parameter int WEIGHT_FRAC_BITS = wlcb_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// layer_r[7:0], layer_g[15:8], layer_b[23:16], weight[39:24],
	// base_r[47:40], base_g[55:48], base_b[63:56]
	input  logic [wlcb_pkg::S_DATA_W-1:0] s_tdata,
	// first[0], has_layer[1]
	input  logic [wlcb_pkg::S_USER_W-1:0] s_tuser,
	input  logic                          s_tlast,
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_r[7:0], out_g[15:8], out_b[23:16]
	output logic [wlcb_pkg::M_DATA_W-1:0] m_tdata,
	// overflow[0]
	output logic                          m_tuser
);

	localparam int CW_  = wlcb_pkg::COLOR_W;
	localparam int NCH  = wlcb_pkg::NUM_CH;
	localparam int LCW  = $clog2(MAX_LAYERS + 1);
	localparam int TW   = wlcb_pkg::WEIGHT_W + LCW;   // total weight
	localparam int SW   = CW_ + TW;                    // channel sum
	localparam int AW   = WEIGHT_FRAC_BITS + 1;        // alpha, 0..ONE
	localparam int PW   = CW_ + AW;                    // base * (ONE - alpha)
	localparam int DW   = TW + WEIGHT_FRAC_BITS;       // D = T * ONE
	localparam int NW   = CW_ + DW;                    // N <= 255 * D
	localparam int RW   = NW + 1;                      // 2N + D
	localparam int DVW  = DW + CW_;                    // 2D << 7
	localparam int STW  = $clog2(TW);
	localparam logic [AW-1:0]  ONE     = AW'(1) << WEIGHT_FRAC_BITS;
	localparam logic [LCW-1:0] MAX_CNT = LCW'(MAX_LAYERS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_PREP,
		ST_MULA,
		ST_MULT,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	// per LED accumulators
	logic [SW-1:0]  sum_q [NCH];
	logic [TW-1:0]  tot_q;
	logic [wlcb_pkg::WEIGHT_W-1:0] peak_q;
	logic [LCW-1:0] cnt_q;
	logic           drop_q;

	// current word and serial datapath
	logic [CW_-1:0] col_q  [NCH];
	logic [CW_-1:0] base_q [NCH];
	logic [SW-1:0]  wsh_q;
	logic           last_q;
	logic [AW-1:0]  mpa_q;
	logic [TW-1:0]  mpt_q;
	logic [NW-1:0]  mcs_q  [NCH];
	logic [PW-1:0]  mcb_q  [NCH];
	logic [PW-1:0]  p1_q   [NCH];
	logic [NW-1:0]  n_q    [NCH];
	logic [RW-1:0]  rem_q  [NCH];
	logic [DVW-1:0] dvs_q;
	logic [CW_-1:0] quo_q  [NCH];
	logic [STW-1:0] step_q;

	// input word fields
	logic                          in_first, in_has;
	logic [CW_-1:0]                in_col  [NCH];
	logic [CW_-1:0]                in_base [NCH];
	logic [wlcb_pkg::WEIGHT_W-1:0] in_w;

	assign in_first   = s_tuser[0];
	assign in_has     = s_tuser[1];
	assign in_col[0]  = s_tdata[7:0];
	assign in_col[1]  = s_tdata[15:8];
	assign in_col[2]  = s_tdata[23:16];
	assign in_w       = s_tdata[39:24];
	assign in_base[0] = s_tdata[47:40];
	assign in_base[1] = s_tdata[55:48];
	assign in_base[2] = s_tdata[63:56];

	assign s_tready = (state_q == ST_IDLE);

	// accumulator values after an optional clear on first
	logic [SW-1:0]  sum_b [NCH];
	logic [TW-1:0]  tot_b;
	logic [wlcb_pkg::WEIGHT_W-1:0] peak_b;
	logic [LCW-1:0] cnt_b;
	logic           drop_b;
	logic           take;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			sum_b[c] = in_first ? '0 : sum_q[c];
		end
		tot_b  = in_first ? '0 : tot_q;
		peak_b = in_first ? '0 : peak_q;
		cnt_b  = in_first ? '0 : cnt_q;
		drop_b = in_first ? 1'b0 : drop_q;
		take   = in_has && (cnt_b < MAX_CNT);
	end

	// alpha = min(peak, ONE)
	logic [AW-1:0] alpha;

	always_comb begin
		if (wlcb_pkg::CMP_W'(peak_q) >= wlcb_pkg::CMP_W'(ONE)) begin
			alpha = ONE;
		end else begin
			alpha = AW'(peak_q);
		end
	end

	// serial multiply and divide steps
	logic           nbit;
	logic [PW-1:0]  p1_nx  [NCH];
	logic [NW-1:0]  n_nx   [NCH];
	logic           ge     [NCH];
	logic [DW-1:0]  den;

	always_comb begin
		nbit = (state_q == ST_MULA) ? mpa_q[0] : mpt_q[0];
		den  = DW'(tot_q) << WEIGHT_FRAC_BITS;
		for (int c = 0; c < NCH; c++) begin
			p1_nx[c] = mpt_q[0] ? (p1_q[c] + mcb_q[c]) : p1_q[c];
			n_nx[c]  = nbit ? (n_q[c] + mcs_q[c]) : n_q[c];
			ge[c]    = rem_q[c] >= RW'(dvs_q);
		end
	end

	// sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			for (int c = 0; c < NCH; c++) begin
				sum_q[c] <= '0;
			end
			tot_q    <= '0;
			peak_q   <= '0;
			cnt_q    <= '0;
			drop_q   <= 1'b0;
			last_q   <= 1'b0;
			step_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			// drop the result word once taken; ST_DONE keeps or reloads it
			if (m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						last_q <= s_tlast;
						wsh_q  <= SW'(in_w);
						step_q <= '0;
						for (int c = 0; c < NCH; c++) begin
							sum_q[c]  <= sum_b[c];
							col_q[c]  <= in_col[c];
							base_q[c] <= in_base[c];
						end
						if (take) begin
							tot_q   <= tot_b + TW'(in_w);
							peak_q  <= (in_w > peak_b) ? in_w : peak_b;
							cnt_q   <= cnt_b + LCW'(1);
							drop_q  <= drop_b;
							state_q <= ST_ACC;
						end else begin
							tot_q   <= tot_b;
							peak_q  <= peak_b;
							cnt_q   <= cnt_b;
							drop_q  <= drop_b | in_has;
							state_q <= s_tlast ? ST_PREP : ST_IDLE;
						end
					end
				end
				ST_ACC: begin
					// add weight << k for each set color bit
					for (int c = 0; c < NCH; c++) begin
						if (col_q[c][0]) begin
							sum_q[c] <= sum_q[c] + wsh_q;
						end
						col_q[c] <= col_q[c] >> 1;
					end
					wsh_q  <= wsh_q << 1;
					step_q <= step_q + STW'(1);
					if (step_q == STW'(CW_ - 1)) begin
						state_q <= last_q ? ST_PREP : ST_IDLE;
					end
				end
				ST_PREP: begin
					step_q <= '0;
					if (tot_q == '0) begin
						// zero total weight: pass the base color
						for (int c = 0; c < NCH; c++) begin
							quo_q[c] <= base_q[c];
						end
						state_q <= ST_DONE;
					end else begin
						mpa_q <= alpha;
						mpt_q <= TW'(ONE - alpha);
						for (int c = 0; c < NCH; c++) begin
							mcs_q[c] <= NW'(sum_q[c]);
							mcb_q[c] <= PW'(base_q[c]);
							p1_q[c]  <= '0;
							n_q[c]   <= '0;
						end
						state_q <= ST_MULA;
					end
				end
				ST_MULA: begin
					// N = S * alpha and P1 = base * (ONE - alpha), one bit a cycle
					for (int c = 0; c < NCH; c++) begin
						n_q[c]   <= n_nx[c];
						p1_q[c]  <= p1_nx[c];
						mcb_q[c] <= mcb_q[c] << 1;
					end
					mpa_q <= mpa_q >> 1;
					if (step_q == STW'(AW - 1)) begin
						// switch the multiplicand to P1 and the multiplier to T
						for (int c = 0; c < NCH; c++) begin
							mcs_q[c] <= NW'(p1_nx[c]);
						end
						mpt_q   <= tot_q;
						step_q  <= '0;
						state_q <= ST_MULT;
					end else begin
						for (int c = 0; c < NCH; c++) begin
							mcs_q[c] <= mcs_q[c] << 1;
						end
						mpt_q  <= mpt_q >> 1;
						step_q <= step_q + STW'(1);
					end
				end
				ST_MULT: begin
					// N += P1 * T, one bit a cycle
					for (int c = 0; c < NCH; c++) begin
						n_q[c]   <= n_nx[c];
						mcs_q[c] <= mcs_q[c] << 1;
					end
					mpt_q <= mpt_q >> 1;
					if (step_q == STW'(TW - 1)) begin
						// set up (2N + D) / (2D); quotient fits 8 bits as N <= 255 * D
						for (int c = 0; c < NCH; c++) begin
							rem_q[c] <= (RW'(n_nx[c]) << 1) + RW'(den);
						end
						dvs_q   <= DVW'(den) << CW_;
						step_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						step_q <= step_q + STW'(1);
					end
				end
				ST_DIV: begin
					// restoring divide, one quotient bit a cycle, MSB first
					for (int c = 0; c < NCH; c++) begin
						if (ge[c]) begin
							rem_q[c] <= rem_q[c] - RW'(dvs_q);
						end
						quo_q[c] <= {quo_q[c][CW_-2:0], ge[c]};
					end
					dvs_q  <= dvs_q >> 1;
					step_q <= step_q + STW'(1);
					if (step_q == STW'(CW_ - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hand over the result and start a new LED
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {quo_q[2], quo_q[1], quo_q[0]};
						m_tuser  <= drop_q;
						for (int c = 0; c < NCH; c++) begin
							sum_q[c] <= '0;
						end
						tot_q   <= '0;
						peak_q  <= '0;
						cnt_q   <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// layer count saturates at the limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("layer count above limit");

	// a dropped contribution means the count is full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> cnt_q == MAX_CNT)
		else $error("overflow flagged with free layer slots");

	// the divider only runs with a nonzero total weight
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> tot_q != '0)
		else $error("divide with zero total weight");

	// the remainder stays below twice the current divisor step
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q[0] < {dvs_q, 1'b0})
		else $error("divider remainder out of range");
`endif

endmodule
